// File: rtl/mecd_pkg.sv
// ----------------------------------------------------------------------------
// mecd_pkg
// Shared types and encoding codes for the multi-encoding character decoder.
// ----------------------------------------------------------------------------
package mecd_pkg;

    localparam int ModeWidth = 3;
    localparam int CodeWidth = 31;

    // encoding select codes, codes 6 and 7 fall back to raw byte
    localparam logic [ModeWidth-1:0] MODE_BYTE     = 3'd0;
    localparam logic [ModeWidth-1:0] MODE_U16_BE   = 3'd1;
    localparam logic [ModeWidth-1:0] MODE_U16_LE   = 3'd2;
    localparam logic [ModeWidth-1:0] MODE_UTF8     = 3'd3;
    localparam logic [ModeWidth-1:0] MODE_UTF16_BE = 3'd4;
    localparam logic [ModeWidth-1:0] MODE_UTF16_LE = 3'd5;

    localparam logic [CodeWidth-1:0] CODE_REPLACEMENT = 31'h0000_FFFD;
    localparam logic [20:0]          SUPPLEMENTARY_BASE = 21'h1_0000;
    localparam logic [5:0]           HIGH_SURROGATE_TAG = 6'b110110;
    localparam logic [5:0]           LOW_SURROGATE_TAG  = 6'b110111;

    typedef struct packed {
        logic [CodeWidth-1:0] code_point;
        logic                 at_end;
    } result_t;

endpackage

// File: rtl/multi_encoding_char_decoder.sv
// ----------------------------------------------------------------------------
// multi_encoding_char_decoder
// Byte stream to character code decoder for raw byte, 16-bit, UTF-8, UTF-16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries one byte (in_byte) or an
//   end-of-stream marker (end_of_stream) per item. Output channel
//   out_valid / out_stall carries code_point and at_end. An item moves on
//   an edge where valid is high and stall is low.
//   The mode register is written through cfg_valid / cfg_ready with the
//   new mode on encoding_mode; cfg_ready is always high and every write
//   clears any partial sequence. Write it only while the decoder is idle.
//   Each accepted byte updates the sequence state in the same cycle; a
//   completed character is registered in the output register, or in the
//   skid register while that register is full and stalled. One item per
//   cycle is accepted for as long as the output drains.
//   When the receiver stalls, one more result is caught in a skid register
//   and in_stall rises only once that skid register is full.
//   Reset selects raw byte mode, clears all sequence state and empties
//   the output and skid registers.
// ----------------------------------------------------------------------------
module multi_encoding_char_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mecd_pkg::ModeWidth-1:0] encoding_mode,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     in_byte,
    input  logic                           end_of_stream,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mecd_pkg::CodeWidth-1:0] code_point,
    output logic                           at_end
);
    import mecd_pkg::*;

    logic [ModeWidth-1:0] mode_reg;
    logic [2:0]           pending_reg, pending_next;
    logic [CodeWidth-1:0] acc_reg, acc_next;
    logic [7:0]           first_byte_reg, first_byte_next;
    logic                 half_seen_reg, half_seen_next;
    logic                 high_held_reg, high_held_next;
    logic [9:0]           high_bits_reg, high_bits_next;

    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic    in_fire, out_fire;
    logic    has_result;
    result_t result;

    logic [15:0]          unit;
    logic [4:0]           cont_shift;
    logic [CodeWidth-1:0] cont_acc;
    logic [20:0]          pair_code;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;

    assign out_valid  = out_valid_reg;
    assign code_point = out_reg.code_point;
    assign at_end     = out_reg.at_end;

    always_comb
    begin
        if (mode_reg == MODE_U16_BE || mode_reg == MODE_UTF16_BE)
        begin
            unit = {first_byte_reg, in_byte};
        end
        else
        begin
            unit = {in_byte, first_byte_reg};
        end
        case (pending_reg)
            3'd2:    cont_shift = 5'd6;
            3'd3:    cont_shift = 5'd12;
            3'd4:    cont_shift = 5'd18;
            3'd5:    cont_shift = 5'd24;
            default: cont_shift = 5'd0;
        endcase
        cont_acc  = acc_reg | (CodeWidth'(in_byte[5:0]) << cont_shift);
        pair_code = 21'({high_bits_reg, unit[9:0]}) + SUPPLEMENTARY_BASE;
    end

    // per-item decode
    always_comb
    begin
        pending_next      = pending_reg;
        acc_next          = acc_reg;
        first_byte_next   = first_byte_reg;
        half_seen_next    = half_seen_reg;
        high_held_next    = high_held_reg;
        high_bits_next    = high_bits_reg;
        has_result        = 1'b0;
        result.code_point = '0;
        result.at_end     = 1'b0;

        if (end_of_stream)
        begin
            pending_next    = '0;
            acc_next        = '0;
            first_byte_next = '0;
            half_seen_next  = 1'b0;
            high_held_next  = 1'b0;
            high_bits_next  = '0;
            has_result      = 1'b1;
            result.at_end   = 1'b1;
        end
        else
        begin
            case (mode_reg)
                MODE_U16_BE, MODE_U16_LE, MODE_UTF16_BE, MODE_UTF16_LE:
                begin
                    if (!half_seen_reg)
                    begin
                        first_byte_next = in_byte;
                        half_seen_next  = 1'b1;
                    end
                    else
                    begin
                        half_seen_next  = 1'b0;
                        first_byte_next = '0;
                        has_result      = 1'b1;
                        result.code_point = CodeWidth'(unit);
                        if (mode_reg == MODE_UTF16_BE || mode_reg == MODE_UTF16_LE)
                        begin
                            if (high_held_reg)
                            begin
                                high_held_next = 1'b0;
                                high_bits_next = '0;
                                if (unit[15:10] == LOW_SURROGATE_TAG)
                                begin
                                    result.code_point = CodeWidth'(pair_code);
                                end
                                else
                                begin
                                    result.code_point = CODE_REPLACEMENT;
                                end
                            end
                            else if (unit[15:10] == HIGH_SURROGATE_TAG)
                            begin
                                high_held_next = 1'b1;
                                high_bits_next = unit[9:0];
                                has_result     = 1'b0;
                            end
                        end
                    end
                end
                MODE_UTF8:
                begin
                    if (pending_reg != 3'd0)
                    begin
                        acc_next     = cont_acc;
                        pending_next = pending_reg - 3'd1;
                        if (pending_reg == 3'd1)
                        begin
                            has_result        = 1'b1;
                            result.code_point = cont_acc;
                        end
                    end
                    else if (!in_byte[7])
                    begin
                        has_result        = 1'b1;
                        result.code_point = CodeWidth'(in_byte);
                    end
                    else if (in_byte < 8'hE0)
                    begin
                        acc_next     = CodeWidth'({in_byte[4:0], 6'b0});
                        pending_next = 3'd1;
                    end
                    else if (in_byte < 8'hF0)
                    begin
                        acc_next     = CodeWidth'({in_byte[3:0], 12'b0});
                        pending_next = 3'd2;
                    end
                    else if (in_byte < 8'hF8)
                    begin
                        acc_next     = CodeWidth'({in_byte[2:0], 18'b0});
                        pending_next = 3'd3;
                    end
                    else if (in_byte < 8'hFC)
                    begin
                        acc_next     = CodeWidth'({in_byte[1:0], 24'b0});
                        pending_next = 3'd4;
                    end
                    else
                    begin
                        acc_next     = CodeWidth'({in_byte[0], 30'b0});
                        pending_next = 3'd5;
                    end
                end
                default:
                begin
                    has_result        = 1'b1;
                    result.code_point = CodeWidth'(in_byte);
                end
            endcase
        end
    end

    // mode and sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_BYTE;
            pending_reg    <= '0;
            acc_reg        <= '0;
            first_byte_reg <= '0;
            half_seen_reg  <= 1'b0;
            high_held_reg  <= 1'b0;
            high_bits_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg       <= encoding_mode;
            pending_reg    <= '0;
            acc_reg        <= '0;
            first_byte_reg <= '0;
            half_seen_reg  <= 1'b0;
            high_held_reg  <= 1'b0;
            high_bits_reg  <= '0;
        end
        else if (in_fire)
        begin
            pending_reg    <= pending_next;
            acc_reg        <= acc_next;
            first_byte_reg <= first_byte_next;
            half_seen_reg  <= half_seen_next;
            high_held_reg  <= high_held_next;
            high_bits_reg  <= high_bits_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire && has_result)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire && has_result)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    // skid entry only holds a result while the output register is full
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // a stalled full buffer keeps both entries
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> (skid_valid_reg && out_valid_reg))
        else $error("result dropped while output stalled");

    // a mode write leaves no partial sequence behind
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> (pending_reg == 3'd0 && !half_seen_reg && !high_held_reg))
        else $error("sequence state survived a mode write");

    a_pending_utf8: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg != 3'd0) |-> (mode_reg == MODE_UTF8))
        else $error("utf-8 continuation pending outside utf-8 mode");

    a_surrogate_utf16: assert property (@(posedge clk) disable iff (!rst_n)
        high_held_reg |-> (mode_reg == MODE_UTF16_BE || mode_reg == MODE_UTF16_LE))
        else $error("high surrogate held outside utf-16 mode");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the multi-encoding character decoder against an in-line decoder
// model. Bytes are pushed in every encoding mode, directed first, then as
// random sequences, well-formed or not, mixed with noise and end-of-stream items,
// with random idling on both sides, a long receiver hold and a sender pause.
// ----------------------------------------------------------------------------
module tb;
    import mecd_pkg::*;

    // mode values with no encoding of their own, decoded as raw bytes
    localparam logic [ModeWidth-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [ModeWidth-1:0] MODE_SPARE_HI = 3'd7;

    localparam int PhaseCount = 11;
    localparam logic [ModeWidth-1:0] PHASE_MODES [PhaseCount] = '{
        MODE_BYTE, MODE_U16_BE, MODE_U16_LE, MODE_UTF8, MODE_UTF16_BE,
        MODE_UTF16_LE, MODE_SPARE_LO, MODE_SPARE_HI, MODE_UTF8,
        MODE_UTF16_LE, MODE_UTF16_BE
    };

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [ModeWidth-1:0] encoding_mode = MODE_BYTE;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [7:0]           in_byte       = 8'h00;
    logic                 end_of_stream = 1'b0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic [CodeWidth-1:0] code_point;
    logic                 at_end;

    // decoder model state
    logic [ModeWidth-1:0] cur_mode = MODE_BYTE;
    logic [2:0]           utf8_left = '0;
    logic [CodeWidth-1:0] utf8_acc = '0;
    logic [7:0]           first_byte = '0;
    logic                 half_seen = 1'b0;
    logic                 hs_held = 1'b0;
    logic [9:0]           hs_bits = '0;

    result_t pending_codes [$];
    int      mismatches = 0;
    int      items_sent = 0;
    bit      calm = 1'b0;
    int      hold_request = 0;
    int      hold_left = 0;

    multi_encoding_char_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .encoding_mode (encoding_mode),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .code_point    (code_point),
        .at_end        (at_end)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void push_code(input logic [CodeWidth-1:0] cp, input logic fin);
        result_t r;
        r.code_point = cp;
        r.at_end     = fin;
        pending_codes.push_back(r);
    endfunction

    function automatic void clear_sequence_state();
        utf8_left  = '0;
        utf8_acc   = '0;
        first_byte = '0;
        half_seen  = 1'b0;
        hs_held    = 1'b0;
        hs_bits    = '0;
    endfunction

    function automatic void decode_utf8(input logic [7:0] b);
        logic [CodeWidth-1:0] cont;
        if (utf8_left != 0)
        begin
            cont      = CodeWidth'(b[5:0]) << (6 * (utf8_left - 1));
            utf8_acc  = utf8_acc | cont;
            utf8_left = utf8_left - 3'd1;
            if (utf8_left == 0)
                push_code(utf8_acc, 1'b0);
        end
        else if (b < 8'h80)
            push_code(CodeWidth'(b), 1'b0);
        else if (b < 8'hE0)
        begin
            utf8_acc  = CodeWidth'(b[4:0]) << 6;
            utf8_left = 3'd1;
        end
        else if (b < 8'hF0)
        begin
            utf8_acc  = CodeWidth'(b[3:0]) << 12;
            utf8_left = 3'd2;
        end
        else if (b < 8'hF8)
        begin
            utf8_acc  = CodeWidth'(b[2:0]) << 18;
            utf8_left = 3'd3;
        end
        else if (b < 8'hFC)
        begin
            utf8_acc  = CodeWidth'(b[1:0]) << 24;
            utf8_left = 3'd4;
        end
        else
        begin
            utf8_acc  = CodeWidth'(b[0]) << 30;
            utf8_left = 3'd5;
        end
    endfunction

    function automatic void decode_utf16_unit(input logic [15:0] unit);
        logic [CodeWidth-1:0] cp;
        if (hs_held)
        begin
            hs_held = 1'b0;
            if (unit >= 16'hDC00 && unit <= 16'hDFFF)
            begin
                cp = (CodeWidth'(hs_bits) << 10) + CodeWidth'(unit - 16'hDC00)
                     + CodeWidth'(SUPPLEMENTARY_BASE);
                push_code(cp, 1'b0);
            end
            else
                push_code(CODE_REPLACEMENT, 1'b0);
            hs_bits = '0;
        end
        else if (unit >= 16'hD800 && unit <= 16'hDBFF)
        begin
            hs_held = 1'b1;
            hs_bits = unit[9:0];
        end
        else
            push_code(CodeWidth'(unit), 1'b0);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eos);
        logic [15:0] unit;
        if (eos)
        begin
            clear_sequence_state();
            push_code('0, 1'b1);
            return;
        end
        case (cur_mode)
            MODE_U16_BE, MODE_U16_LE, MODE_UTF16_BE, MODE_UTF16_LE:
            begin
                if (!half_seen)
                begin
                    first_byte = b;
                    half_seen  = 1'b1;
                end
                else
                begin
                    half_seen = 1'b0;
                    if (cur_mode == MODE_U16_BE || cur_mode == MODE_UTF16_BE)
                        unit = {first_byte, b};
                    else
                        unit = {b, first_byte};
                    first_byte = '0;
                    if (cur_mode == MODE_UTF16_BE || cur_mode == MODE_UTF16_LE)
                        decode_utf16_unit(unit);
                    else
                        push_code(CodeWidth'(unit), 1'b0);
                end
            end
            MODE_UTF8:
                decode_utf8(b);
            default:
                push_code(CodeWidth'(b), 1'b0);
        endcase
    endfunction

    function automatic int idle_gap();
        int n;
        n = 0;
        if (calm)
            return 0;
        while ($urandom_range(99) < 28 && n < 40)
            n++;
        return n;
    endfunction

    // called and returns at a falling edge
    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        in_byte       <= b;
        end_of_stream <= eos;
        do
            @(posedge clk);
        while (in_stall);
        decode_byte(b, eos);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_unit(input logic [15:0] u);
        if (cur_mode == MODE_U16_BE || cur_mode == MODE_UTF16_BE)
        begin
            send_item(u[15:8], 1'b0);
            send_item(u[7:0], 1'b0);
        end
        else
        begin
            send_item(u[7:0], 1'b0);
            send_item(u[15:8], 1'b0);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(negedge clk);
        // an item with no result may still be in flight
        repeat (3) @(negedge clk);
    endtask

    task automatic set_mode(input logic [ModeWidth-1:0] m);
        wait_drained();
        cfg_valid     <= 1'b1;
        encoding_mode <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_mode = m;
        clear_sequence_state();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one character, one noise byte or one end-of-stream item in the current mode
    task automatic send_random_chunk();
        int          r;
        int          len;
        logic [7:0]  lead;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [15:0] u;
        r = $urandom_range(99);
        if (r < 4)
            send_item(8'($urandom), 1'b1);
        else if (r < 10)
            send_item(8'($urandom), 1'b0);
        else
        begin
            r  = $urandom_range(99);
            hi = 16'hD800 | 16'($urandom_range(1023));
            lo = 16'hDC00 | 16'($urandom_range(1023));
            case (cur_mode)
                MODE_UTF8:
                begin
                    len = r < 35 ? 1 : r < 60 ? 2 : r < 78 ? 3 : r < 90 ? 4 : r < 95 ? 5 : 6;
                    case (len)
                        1:       lead = 8'($urandom_range(8'h7F, 8'h00));
                        2:       lead = 8'($urandom_range(8'hDF, 8'h80));
                        3:       lead = 8'($urandom_range(8'hEF, 8'hE0));
                        4:       lead = 8'($urandom_range(8'hF7, 8'hF0));
                        5:       lead = 8'($urandom_range(8'hFB, 8'hF8));
                        default: lead = 8'($urandom_range(8'hFF, 8'hFC));
                    endcase
                    send_item(lead, 1'b0);
                    // continuation top bits are not checked, so sometimes break them
                    repeat (len - 1)
                        send_item(($urandom_range(9) == 0) ? 8'($urandom)
                                                           : {2'b10, 6'($urandom)}, 1'b0);
                end
                MODE_UTF16_BE, MODE_UTF16_LE:
                begin
                    if (r < 40)
                    begin
                        send_unit(hi);
                        send_unit(lo);
                    end
                    else if (r < 55)
                    begin
                        u = 16'($urandom);
                        if (u >= 16'hDC00 && u <= 16'hDFFF)
                            u = u ^ 16'h0400;
                        send_unit(hi);
                        send_unit(u);
                    end
                    else if (r < 65)
                        send_unit(lo);
                    else if (r < 75)
                    begin
                        send_unit(hi);
                        send_unit(16'hD800 | 16'($urandom_range(1023)));
                    end
                    else
                        send_unit(16'($urandom));
                end
                MODE_U16_BE, MODE_U16_LE:
                    send_unit(16'($urandom));
                default:
                    send_item(8'($urandom), 1'b0);
            endcase
        end
    endtask

    task automatic test_directed();
        set_mode(MODE_BYTE);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        set_mode(MODE_UTF8);
        send_item(8'h7F, 1'b0);
        // continuation-range byte taken as a two-byte lead
        send_item(8'h80, 1'b0);
        send_item(8'h3F, 1'b0);
        send_item(8'hF0, 1'b0);
        send_item(8'h9F, 1'b0);
        send_item(8'h98, 1'b0);
        send_item(8'h80, 1'b0);
        // six-byte lead, largest code
        send_item(8'hFD, 1'b0);
        repeat (5) send_item(8'hBF, 1'b0);
        // partial sequence dropped at end of stream
        send_item(8'hE2, 1'b0);
        send_item(8'h00, 1'b1);
        set_mode(MODE_UTF16_BE);
        send_unit(16'hD83D);
        send_unit(16'hDE00);
        send_unit(16'hD800);
        send_unit(16'h0041);
        send_unit(16'hDC00);
    endtask

    task automatic test_random_modes();
        int start;
        foreach (PHASE_MODES[i])
        begin
            set_mode(PHASE_MODES[i]);
            start = items_sent;
            while (items_sent - start < 40)
                send_random_chunk();
        end
    endtask

    task automatic test_streaming();
        int start;
        set_mode(MODE_UTF16_LE);
        calm  = 1'b1;
        start = items_sent;
        while (items_sent - start < 80)
            send_random_chunk();
        calm = 1'b0;
    endtask

    task automatic test_pressure();
        set_mode(MODE_BYTE);
        // receiver holds off while the sender keeps offering items
        calm         = 1'b1;
        hold_request = 80;
        repeat (30) send_item(8'($urandom), 1'b0);
        calm = 1'b0;
        repeat (10) send_item(8'($urandom), 1'b0);
        // sender pauses until everything has come out
        wait_drained();
        repeat (10) send_item(8'($urandom), 1'b0);
    endtask

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 28);
    end

    always @(posedge clk)
    begin : check_results
        result_t exp_code;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_codes.size() == 0)
            begin
                $error("unexpected item: code_point %h at_end %b", code_point, at_end);
                mismatches++;
            end
            else
            begin
                exp_code = pending_codes.pop_front();
                if (code_point !== exp_code.code_point)
                begin
                    $error("code_point: expected %h, actual %h", exp_code.code_point, code_point);
                    mismatches++;
                end
                if (at_end !== exp_code.at_end)
                begin
                    $error("at_end: expected %b, actual %b", exp_code.at_end, at_end);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_modes();
        test_streaming();
        test_pressure();
        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: multi_encoding_char_decoder.f
rtl/mecd_pkg.sv
rtl/multi_encoding_char_decoder.sv
tb/sv/tb.sv
